// ===== sv/packet_rx_deframer_checksum_assert.svh =====
// assertion macros for the packet deframer checker
// expects a clock clk_i and an active-low reset rst_ni in the including scope
`ifndef PACKET_RX_DEFRAMER_CHECKSUM_ASSERT_SVH
`define PACKET_RX_DEFRAMER_CHECKSUM_ASSERT_SVH

// same-cycle implication
`define PRXD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRXD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/prxd_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the sync-header packet deframer
// no dependencies
package prxd_pkg;

  // parser phases
  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhAddr    = 3'd1;
  localparam logic [2:0] PhCmd     = 3'd2;
  localparam logic [2:0] PhSeq     = 3'd3;
  localparam logic [2:0] PhLen     = 3'd4;
  localparam logic [2:0] PhPayload = 3'd5;

  // sync header bytes
  localparam logic [7:0] Sync0 = 8'hDE;
  localparam logic [7:0] Sync1 = 8'h7E;
  localparam logic [7:0] Sync2 = 8'hC7;
  localparam logic [7:0] Sync3 = 8'hED;

  localparam logic KindWord = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [1:0] StatusGood     = 2'd0;
  localparam logic [1:0] StatusBadSum   = 2'd1;
  localparam logic [1:0] StatusOversize = 2'd2;

  localparam logic [15:0] MaxPayloadReset = 16'd256;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [15:0] payload_word;
    logic [15:0] address;
    logic [15:0] opcode;
    logic [15:0] seq_number;
    logic [15:0] payload_length;
    logic [1:0]  status;
  } result_t;

  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = Sync0;
      2'd1:    b = Sync1;
      2'd2:    b = Sync2;
      default: b = Sync3;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/prxd_core.sv =====
`timescale 1ns / 1ps
// parser state and per-byte next-state logic of the packet deframer
// depends on prxd_pkg
module prxd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  output prxd_pkg::result_t res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [16:0] idx_q, idx_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] max_q;

  logic [15:0] field_cur;
  logic [15:0] field_new;
  logic        field_done;
  logic [16:0] idx_inc;
  logic [16:0] hunt_idx;
  logic [15:0] word;

  assign idx_inc  = idx_q + 17'd1;
  assign word     = {hold_q, rx_byte_i};
  assign field_done = (idx_q == 17'd1);

  always_comb begin
    case (phase_q)
      prxd_pkg::PhAddr: field_cur = addr_q;
      prxd_pkg::PhCmd:  field_cur = cmd_q;
      prxd_pkg::PhSeq:  field_cur = seq_q;
      default:          field_cur = len_q;
    endcase
    // big-endian merge, high byte on the even position
    if (idx_q[0]) begin
      field_new = field_cur | {8'h00, rx_byte_i};
    end else begin
      field_new = field_cur | {rx_byte_i, 8'h00};
    end
  end

  always_comb begin
    if ((idx_q[16:2] == 15'd0) && (rx_byte_i == prxd_pkg::sync_byte(idx_q[1:0]))) begin
      hunt_idx = idx_inc;
    end else begin
      hunt_idx = 17'd0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    addr_d  = addr_q;
    cmd_d   = cmd_q;
    seq_d   = seq_q;
    len_d   = len_q;
    sum_d   = sum_q;
    hold_d  = hold_q;
    res_o.valid        = 1'b0;
    res_o.kind         = prxd_pkg::KindWord;
    res_o.payload_word = 16'd0;
    res_o.status       = prxd_pkg::StatusGood;

    case (phase_q)
      prxd_pkg::PhHunt: begin
        sum_d = 16'd0;
        idx_d = hunt_idx;
        if (hunt_idx == 17'd4) begin
          addr_d  = 16'd0;
          cmd_d   = 16'd0;
          seq_d   = 16'd0;
          len_d   = 16'd0;
          idx_d   = 17'd0;
          phase_d = prxd_pkg::PhAddr;
        end
      end
      prxd_pkg::PhAddr, prxd_pkg::PhCmd, prxd_pkg::PhSeq, prxd_pkg::PhLen: begin
        case (phase_q)
          prxd_pkg::PhAddr: addr_d = field_new;
          prxd_pkg::PhCmd:  cmd_d  = field_new;
          prxd_pkg::PhSeq:  seq_d  = field_new;
          default:          len_d  = field_new;
        endcase
        idx_d = idx_inc;
        if (field_done) begin
          sum_d = sum_q + field_new;
          idx_d = 17'd0;
          case (phase_q)
            prxd_pkg::PhAddr: phase_d = prxd_pkg::PhCmd;
            prxd_pkg::PhCmd:  phase_d = prxd_pkg::PhSeq;
            prxd_pkg::PhSeq:  phase_d = prxd_pkg::PhLen;
            default: begin
              if (field_new > max_q) begin
                phase_d      = prxd_pkg::PhHunt;
                res_o.valid  = 1'b1;
                res_o.kind   = prxd_pkg::KindEnd;
                res_o.status = prxd_pkg::StatusOversize;
              end else begin
                phase_d = prxd_pkg::PhPayload;
              end
            end
          endcase
        end
      end
      prxd_pkg::PhPayload: begin
        if (idx_q[0]) begin
          sum_d = sum_q + word;
        end else begin
          hold_d = rx_byte_i;
        end
        idx_d = idx_inc;
        if (idx_inc == ({1'b0, len_q} + 17'd2)) begin
          phase_d      = prxd_pkg::PhHunt;
          idx_d        = 17'd0;
          res_o.valid  = 1'b1;
          res_o.kind   = prxd_pkg::KindEnd;
          res_o.status = (sum_d == 16'd0) ? prxd_pkg::StatusGood : prxd_pkg::StatusBadSum;
        end else if (idx_q[0]) begin
          res_o.valid        = 1'b1;
          res_o.payload_word = word;
        end
      end
      default: begin
        phase_d = prxd_pkg::PhHunt;
        idx_d   = 17'd0;
      end
    endcase

    res_o.address        = addr_d;
    res_o.opcode         = cmd_d;
    res_o.seq_number     = seq_d;
    res_o.payload_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= prxd_pkg::PhHunt;
      idx_q   <= 17'd0;
      addr_q  <= 16'd0;
      cmd_q   <= 16'd0;
      seq_q   <= 16'd0;
      len_q   <= 16'd0;
      sum_q   <= 16'd0;
      hold_q  <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      addr_q  <= addr_d;
      cmd_q   <= cmd_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      hold_q  <= hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= prxd_pkg::MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== sv/packet_rx_deframer_checksum.sv =====
`timescale 1ns / 1ps
// top level of the sync-header packet deframer with 16-bit checksum
// depends on prxd_pkg and prxd_core
//
// Takes one received byte per transfer and hunts for the header DE 7E C7 ED,
// then reads address, command, sequence and length (16-bit, big-endian).
// Payload and checksum bytes pair into words; each word before the last byte
// comes out as a word result (kind 0), and the last byte gives an end result
// (kind 1) with status good, bad checksum, or oversize when the length is
// above the configured maximum length (written through cfg_we_i / cfg_wdata_i, reset 256).
// The parser updates on the accepting edge and the byte's result sits in a one-entry
// output register the cycle after. in_ready_o is high while that register is
// empty or being drained, so bytes flow at one per cycle whenever the consumer
// keeps out_ready_i high.
module packet_rx_deframer_checksum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [15:0] payload_word_o,
  output logic [15:0] address_o,
  output logic [15:0] opcode_o,
  output logic [15:0] seq_number_o,
  output logic [15:0] payload_length_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  prxd_pkg::result_t res;
  prxd_pkg::result_t out_q;
  logic              out_valid_q, out_valid_d;
  logic              in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  prxd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_xfer),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = res.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, loaded only when a new result is produced
  always_ff @(posedge clk_i) begin
    if (in_xfer && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign payload_word_o   = out_q.payload_word;
  assign address_o        = out_q.address;
  assign opcode_o         = out_q.opcode;
  assign seq_number_o     = out_q.seq_number;
  assign payload_length_o = out_q.payload_length;
  assign status_o         = out_q.status;

endmodule

// ===== sv/prxd_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the packet deframer, bound to the top level
// depends on prxd_pkg and packet_rx_deframer_checksum_assert.svh
`include "packet_rx_deframer_checksum_assert.svh"

module prxd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        kind_o,
  input logic [15:0] payload_word_o,
  input logic [15:0] address_o,
  input logic [15:0] opcode_o,
  input logic [15:0] seq_number_o,
  input logic [15:0] payload_length_o,
  input logic [1:0]  status_o
);

  // a stalled result keeps its contents
  `PRXD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o) && $stable(payload_word_o) && $stable(status_o) && $stable(payload_length_o), "result changed while stalled")

  // an empty output register never blocks input
  `PRXD_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o, "input blocked with empty output")

  // word results carry good status
  `PRXD_ASSERT_NOW(a_word_status, out_valid_o && (kind_o == prxd_pkg::KindWord), status_o == prxd_pkg::StatusGood, "word result with nonzero status")

  // end results carry a zero word and a defined status
  `PRXD_ASSERT_NOW(a_end_fields, out_valid_o && (kind_o == prxd_pkg::KindEnd), (payload_word_o == 16'd0) && (status_o != 2'd3), "malformed end result")

endmodule

bind packet_rx_deframer_checksum prxd_checker u_prxd_checker (.*);

// ===== test/prxd_frame_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the sync-header packet deframer: predicts word and end results
// from the byte transfers it sees and compares them with the output transfers
// depends on prxd_pkg
module prxd_frame_checker
  import prxd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [15:0] payload_word_i,
  input  logic [15:0] address_i,
  input  logic [15:0] opcode_i,
  input  logic [15:0] seq_number_i,
  input  logic [15:0] payload_length_i,
  input  logic [1:0]  status_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          results_pending_o
);

  logic [7:0]  header_bytes [4] = '{Sync0, Sync1, Sync2, Sync3};

  logic [2:0]  phase_q;
  logic [16:0] pos_q;
  logic [15:0] addr_q;
  logic [15:0] cmd_q;
  logic [15:0] seq_q;
  logic [15:0] len_q;
  logic [15:0] sum_q;
  logic [15:0] max_len_q;
  logic [7:0]  high_q;
  result_t     frame_results_q [$];

  function automatic result_t frame_result(input logic kind, input logic [15:0] word,
                                           input logic [1:0] status);
    result_t r;
    r.valid          = 1'b1;
    r.kind           = kind;
    r.payload_word   = word;
    r.address        = addr_q;
    r.opcode         = cmd_q;
    r.seq_number     = seq_q;
    r.payload_length = len_q;
    r.status         = status;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] field;
    logic [15:0] word;
    logic        word_done;
    field     = '0;
    word      = '0;
    word_done = 1'b0;
    case (phase_q)
      PhHunt: begin
        sum_q = '0;
        // a byte that breaks the match is not retried as a first header byte
        if (pos_q < 17'd4 && b == header_bytes[pos_q[1:0]]) pos_q = pos_q + 17'd1;
        else pos_q = '0;
        if (pos_q == 17'd4) begin
          addr_q  = '0;
          cmd_q   = '0;
          seq_q   = '0;
          len_q   = '0;
          sum_q   = '0;
          pos_q   = '0;
          phase_q = PhAddr;
        end
      end
      PhAddr, PhCmd, PhSeq, PhLen: begin
        case (phase_q)
          PhAddr:  field = addr_q;
          PhCmd:   field = cmd_q;
          PhSeq:   field = seq_q;
          default: field = len_q;
        endcase
        // big-endian fields: even position fills the high byte
        if (pos_q[0]) field = field | {8'h00, b};
        else field = field | {b, 8'h00};
        pos_q = pos_q + 17'd1;
        case (phase_q)
          PhAddr:  addr_q = field;
          PhCmd:   cmd_q = field;
          PhSeq:   seq_q = field;
          default: len_q = field;
        endcase
        if (pos_q == 17'd2) begin
          sum_q = sum_q + field;
          pos_q = '0;
          case (phase_q)
            PhAddr: phase_q = PhCmd;
            PhCmd:  phase_q = PhSeq;
            PhSeq:  phase_q = PhLen;
            default: begin
              if (len_q > max_len_q) begin
                phase_q = PhHunt;
                frame_results_q.push_back(frame_result(KindEnd, '0, StatusOversize));
              end else begin
                phase_q = PhPayload;
              end
            end
          endcase
        end
      end
      PhPayload: begin
        if (pos_q[0]) begin
          word      = {high_q, b};
          sum_q     = sum_q + word;
          word_done = 1'b1;
        end else begin
          high_q = b;
        end
        pos_q = pos_q + 17'd1;
        // payload plus two checksum bytes; the word closed by the last byte is not sent
        if (pos_q == {1'b0, len_q} + 17'd2) begin
          phase_q = PhHunt;
          pos_q   = '0;
          frame_results_q.push_back(frame_result(KindEnd, '0,
                                    (sum_q == 16'h0000) ? StatusGood : StatusBadSum));
        end else if (word_done) begin
          frame_results_q.push_back(frame_result(KindWord, word, StatusGood));
        end
      end
      default: begin
        phase_q = PhHunt;
        pos_q   = '0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] expected,
                             input logic [15:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, expected, actual);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      phase_q   = PhHunt;
      pos_q     = '0;
      addr_q    = '0;
      cmd_q     = '0;
      seq_q     = '0;
      len_q     = '0;
      sum_q     = '0;
      high_q    = '0;
      max_len_q = MaxPayloadReset;
      frame_results_q.delete();
    end else begin
      if (cfg_we_i) max_len_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) deframe_byte(rx_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result transfer: expected none, actual kind %h word %h",
                   $time, kind_i, payload_word_i);
          fail_count_o++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("kind", {15'd0, want.kind}, {15'd0, kind_i});
          check_field("payload_word", want.payload_word, payload_word_i);
          check_field("address", want.address, address_i);
          check_field("opcode", want.opcode, opcode_i);
          check_field("seq_number", want.seq_number, seq_number_i);
          check_field("payload_length", want.payload_length, payload_length_i);
          check_field("status", {14'd0, want.status}, {14'd0, status_i});
        end
      end
    end
    results_pending_o = frame_results_q.size();
  end

endmodule

// ===== test/tb_packet_rx_deframer_checksum.sv =====
`timescale 1ns / 1ps
// testbench top for the sync-header packet deframer: clock, reset, byte and
// config stimulus, output backpressure and the verdict
// depends on prxd_pkg, packet_rx_deframer_checksum and prxd_frame_checker
module tb_packet_rx_deframer_checksum;
  import prxd_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomBytes = 1050;
  localparam int LongHold    = 300;
  localparam int CfgEvery    = 150;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;

  logic        in_ready_o;
  logic        out_valid_o;
  logic        kind_o;
  logic [15:0] payload_word_o;
  logic [15:0] address_o;
  logic [15:0] opcode_o;
  logic [15:0] seq_number_o;
  logic [15:0] payload_length_o;
  logic [1:0]  status_o;

  int          fail_count;
  int          results_pending;
  int          cycle_count = 0;
  int          hold_req    = 0;
  int          hold_done   = 0;
  bit          tx_calm     = 1'b0;
  logic [15:0] max_len     = MaxPayloadReset;
  logic [7:0]  pkt_q [$];

  packet_rx_deframer_checksum dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .payload_word_o  (payload_word_o),
    .address_o       (address_o),
    .opcode_o        (opcode_o),
    .seq_number_o    (seq_number_o),
    .payload_length_o(payload_length_o),
    .status_o        (status_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  prxd_frame_checker frame_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_i           (kind_o),
    .payload_word_i   (payload_word_o),
    .address_i        (address_o),
    .opcode_i         (opcode_o),
    .seq_number_i     (seq_number_o),
    .payload_length_i (payload_length_o),
    .status_i         (status_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .fail_count_o     (fail_count),
    .results_pending_o(results_pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: random backpressure, calm stretches and requested long holds
  initial begin : result_sink
    int n;
    int calm_left;
    calm_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_done++;
      end else if (calm_left > 0) begin
        out_ready_i <= 1'b1;
        calm_left--;
      end else begin
        n = $urandom_range(99);
        if (n < 2) calm_left = $urandom_range(50, 200);
        if (n < 75) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          if (n < 97) repeat ($urandom_range(0, 2)) @(posedge clk_i);
          else repeat ($urandom_range(10, 40)) @(posedge clk_i);
        end
      end
    end
  end

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(3))
        0:       b = Sync0;
        1:       b = Sync1;
        2:       b = Sync2;
        default: b = Sync3;
      endcase
    end else begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  function automatic logic [15:0] rand_field();
    int n;
    n = $urandom_range(9);
    if (n == 0) return 16'h0000;
    if (n == 1) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  // called at a rising edge; returns at the edge where the byte transfer happens
  task automatic send_byte(input logic [7:0] b);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int n;
    int r;
    n = 0;
    if (!tx_calm) begin
      r = $urandom_range(99);
      if (r >= 95) n = $urandom_range(5, 30);
      else if (r >= 70) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_queue();
    foreach (pkt_q[i]) begin
      idle_gap();
      send_byte(pkt_q[i]);
    end
  endtask

  // sender pauses until every expected result is out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (results_pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max(input logic [15:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    max_len      = v;
  endtask

  // header, four fields, then payload and checksum unless header_only
  task automatic build_packet(input logic [15:0] a, input logic [15:0] c,
                              input logic [15:0] s, input logic [15:0] l,
                              input bit good, input bit header_only);
    logic [7:0]  body [$];
    logic [15:0] sum;
    logic [15:0] ck;
    int          i;
    pkt_q = '{Sync0, Sync1, Sync2, Sync3, a[15:8], a[7:0], c[15:8], c[7:0],
              s[15:8], s[7:0], l[15:8], l[7:0]};
    if (!header_only) begin
      sum = a + c + s + l;
      for (i = 0; i < l; i++) body.push_back(8'($urandom_range(255)));
      for (i = 0; i + 1 < l; i += 2) sum = sum + {body[i], body[i+1]};
      ck = -sum;
      if (!good) ck = ck + 16'($urandom_range(1, 65535));
      if (l[0]) begin
        // odd length: last payload byte and first checksum byte make the last counted word
        body[l-1] = ck[15:8];
        body.push_back(ck[7:0]);
        body.push_back(8'($urandom_range(255)));
      end else begin
        body.push_back(ck[15:8]);
        body.push_back(ck[7:0]);
      end
      pkt_q = {pkt_q, body};
    end
  endtask

  function automatic logic [15:0] pick_max(input int step);
    int n;
    if (step == 0) return 16'h0000;
    if (step == 1) return 16'hFFFF;
    n = $urandom_range(9);
    if (n == 0) return 16'h0000;
    if (n == 1) return 16'hFFFF;
    if (n == 2) return MaxPayloadReset;
    if (n == 3) return 16'd1;
    return 16'($urandom_range(2, 40));
  endfunction

  // returns 0 for a run of noise bytes and 1 for every other item, cut-short headers included
  task automatic make_random_item(output bit counted);
    int          r;
    int          cap;
    int          n;
    logic [15:0] l;
    counted = 1'b1;
    cap = (max_len > 24) ? 24 : max_len;
    l = 16'($urandom_range(0, cap));
    if ($urandom_range(24) == 0 && max_len <= 300) l = max_len;
    r = $urandom_range(99);
    if (r < 85 && (r < 75 || max_len == 16'hFFFF)) begin
      build_packet(rand_field(), rand_field(), rand_field(), l, r < 60, 1'b0);
    end else if (r < 85) begin
      if ($urandom_range(1) == 0) l = max_len + 16'd1;
      else l = 16'($urandom_range(max_len + 1, 65535));
      build_packet(rand_field(), rand_field(), rand_field(), l, 1'b1, 1'b1);
    end else if (r < 93) begin
      counted = 1'b0;
      pkt_q.delete();
      repeat ($urandom_range(1, 8)) pkt_q.push_back(noise_byte());
    end else if (r < 97) begin
      // header cut short, then a stray byte
      n = $urandom_range(1, 3);
      pkt_q = '{Sync0, Sync1, Sync2};
      while (pkt_q.size() > n) void'(pkt_q.pop_back());
      pkt_q.push_back(noise_byte());
    end else begin
      // truncated packet: following bytes run into its payload
      build_packet(rand_field(), rand_field(), rand_field(), l, 1'b1, 1'b0);
      repeat ($urandom_range(1, 3)) void'(pkt_q.pop_back());
    end
  endtask

  initial begin : stimulus
    int sent;
    int cfg_step;
    int next_cfg_at;
    int calm_pkts;
    bit counted;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // broken header: the byte that breaks the match is not retried
    pkt_q = '{Sync0, Sync1, Sync0, Sync1, Sync2, Sync3, 8'h00};
    send_queue();
    // empty payload, extreme field values
    build_packet(16'hFFFF, 16'h0000, 16'hFFFF, 16'd0, 1'b1, 1'b0);
    send_queue();
    // odd length, trailing byte held
    build_packet(16'h0000, 16'hFFFF, 16'h0000, 16'd1, 1'b1, 1'b0);
    send_queue();
    // bad checksum with payload words
    build_packet(16'h1234, 16'h00FF, 16'hFF00, 16'd4, 1'b0, 1'b0);
    send_queue();
    // largest length against the reset maximum
    build_packet(16'hA5A5, 16'h5A5A, 16'h0001, 16'hFFFF, 1'b1, 1'b1);
    send_queue();
    write_max(16'd3);
    build_packet(16'h0F0F, 16'hF0F0, 16'h8000, 16'd3, 1'b1, 1'b0);
    send_queue();
    build_packet(16'h7FFF, 16'h0001, 16'h8001, 16'd4, 1'b1, 1'b1);
    send_queue();

    sent        = 0;
    cfg_step    = 0;
    next_cfg_at = 0;
    calm_pkts   = 0;
    while (sent < RandomBytes) begin
      if (sent >= next_cfg_at) begin
        write_max(pick_max(cfg_step));
        cfg_step++;
        next_cfg_at += CfgEvery;
        if (cfg_step == 3 || cfg_step == 6) begin
          // output held off while bytes keep coming
          hold_req++;
          calm_pkts = 8;
        end
      end
      if (calm_pkts > 0) begin
        tx_calm = 1'b1;
        calm_pkts--;
      end else begin
        tx_calm = ($urandom_range(9) == 0);
      end
      make_random_item(counted);
      send_queue();
      if (counted) sent += pkt_q.size();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
